// File: sv/nsf_pkg.sv
// Package for the new sender filter: beat types, frame codes and the
// lookup handshake between the top level and the address table.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package nsf_pkg;

   localparam int MAC_W = 48;

   localparam logic [1:0] KIND_MGMT    = 2'd0;
   localparam logic [1:0] KIND_DATA    = 2'd1;
   localparam logic [1:0] KIND_CONTROL = 2'd2;
   localparam logic [1:0] KIND_MISC    = 2'd3;

   localparam logic [7:0] FC_BEACON     = 8'h80;
   localparam logic [7:0] FC_PROBE_RESP = 8'h50;
   localparam logic [7:0] SSID_LIMIT    = 8'd33;

   localparam logic REPORT_BEACON = 1'b0;
   localparam logic REPORT_DATA   = 1'b1;

   typedef struct packed {
      logic [1:0]       frame_kind;
      logic [7:0]       frame_control;
      logic [7:0]       ssid_length;
      logic [MAC_W-1:0] sender_mac;
      logic signed [7:0] signal_strength;
   } req_beat_type;

   typedef struct packed {
      logic              report_kind;
      logic [MAC_W-1:0]  new_mac;
      logic signed [7:0] report_strength;
   } rsp_beat_type;

   typedef struct packed {
      logic             start;
      logic [MAC_W-1:0] mac;
   } lookup_req_type;

   typedef struct packed {
      logic done;
      logic is_new;
   } lookup_rsp_type;

endpackage

`default_nettype wire

// File: sv/wlan_new_sender_filter.sv
// Top level of the new sender filter: frame qualification, search control
// and the result register. Depends on nsf_pkg and nsf_table.
//
//   Channel  Ports                          Direction  Beat
//   request  req_valid req_stall req_data   in         one frame header
//   response rsp_valid rsp_stall rsp_data   out        one new sender report
//
// A frame that does not qualify is taken and dropped without a search.
// A new sender holds the request side through a scan of all N filled table
// entries (N at most TABLE_DEPTH) by the one-entry-per-cycle scan of the
// address memory, then an insert; a known sender found at entry j (counting
// from 0) ends the scan at that entry.
// Reset clears the fill count and ring pointer; memory contents need no clear.
// A new sender waits while a stalled response holds its beat; a search may run
// underneath that beat.
`default_nettype none

module wlan_new_sender_filter #(
   parameter int TABLE_DEPTH = 128
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  nsf_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output nsf_pkg::rsp_beat_type rsp_data
);

   typedef enum logic [1:0] {
      T_IDLE,
      T_SEARCH,
      T_HOLD
   } state_type;

   state_type                state_ff;
   logic                     start_ff;
   nsf_pkg::rsp_beat_type    item_ff;
   logic                     rsp_valid_ff;
   nsf_pkg::rsp_beat_type    rsp_data_ff;

   nsf_pkg::lookup_req_type  lookup_req;
   nsf_pkg::lookup_rsp_type  lookup_rsp;

   logic                     accept;
   logic                     mgmt_ok;
   logic                     data_ok;
   logic                     rsp_free;

   assign accept  = req_valid && !req_stall;
   assign mgmt_ok = (req_data.frame_kind == nsf_pkg::KIND_MGMT)
                    && ((req_data.frame_control == nsf_pkg::FC_BEACON)
                        || (req_data.frame_control == nsf_pkg::FC_PROBE_RESP))
                    && (req_data.ssid_length != 8'd0)
                    && (req_data.ssid_length < nsf_pkg::SSID_LIMIT);
   assign data_ok  = req_data.frame_kind == nsf_pkg::KIND_DATA;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = state_ff != T_IDLE;

   assign lookup_req = {start_ff, item_ff.new_mac};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (accept && (mgmt_ok || data_ok)) begin
                  item_ff.report_kind     <= data_ok ? nsf_pkg::REPORT_DATA
                                                     : nsf_pkg::REPORT_BEACON;
                  item_ff.new_mac         <= req_data.sender_mac;
                  item_ff.report_strength <= req_data.signal_strength;
                  start_ff                <= 1'b1;
                  state_ff                <= T_SEARCH;
               end
            end
            T_SEARCH: begin
               if (lookup_rsp.done) begin
                  state_ff <= lookup_rsp.is_new ? T_HOLD : T_IDLE;
               end
            end
            T_HOLD: begin
               if (rsp_free) begin
                  rsp_data_ff  <= item_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   nsf_table #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .lookup_req (lookup_req),
      .lookup_rsp (lookup_rsp)
   );

endmodule

`default_nettype wire

// File: sv/nsf_table.sv
// Seen-address table: one synchronous memory scanned one entry per cycle,
// with first-in first-out replacement once full.
// Depends on nsf_pkg for the lookup request and response types.
`default_nettype none

module nsf_table #(
   parameter int TABLE_DEPTH = 128
) (
   input  wire                     clock,
   input  wire                     reset,
   input  nsf_pkg::lookup_req_type lookup_req,
   output nsf_pkg::lookup_rsp_type lookup_rsp
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT
   } state_type;

   state_type                   state_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [IDX_W-1:0]            oldest_ff;
   logic [CNT_W-1:0]            idx_ff;
   logic                        pend_ff;
   logic [nsf_pkg::MAC_W-1:0]   mac_ff;
   nsf_pkg::lookup_rsp_type     lookup_rsp_ff;

   logic [nsf_pkg::MAC_W-1:0]   seen_mem_ff [TABLE_DEPTH];
   logic [nsf_pkg::MAC_W-1:0]   rd_data_ff;

   logic                        hit;
   logic                        more;
   logic                        full;
   logic                        mem_re;
   logic                        mem_we;
   logic [IDX_W-1:0]            wr_addr;

   assign hit     = pend_ff && (rd_data_ff == mac_ff);
   assign more    = idx_ff < count_ff;
   assign full    = count_ff == CNT_W'(TABLE_DEPTH);
   assign mem_re  = (state_ff == ST_SCAN) && !hit && more;
   assign mem_we  = state_ff == ST_INSERT;
   assign wr_addr = full ? oldest_ff : count_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         seen_mem_ff[wr_addr] <= mac_ff;
      end
      if (mem_re) begin
         rd_data_ff <= seen_mem_ff[idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         oldest_ff     <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         lookup_rsp_ff <= '0;
      end else begin
         lookup_rsp_ff <= '0;
         unique case (state_ff)
            ST_IDLE: begin
               if (lookup_req.start) begin
                  mac_ff   <= lookup_req.mac;
                  idx_ff   <= '0;
                  pend_ff  <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  pend_ff              <= 1'b0;
                  lookup_rsp_ff.done   <= 1'b1;
                  lookup_rsp_ff.is_new <= 1'b0;
                  state_ff             <= ST_IDLE;
               end else if (more) begin
                  idx_ff  <= idx_ff + CNT_W'(1);
                  pend_ff <= 1'b1;
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_INSERT;
               end
            end
            ST_INSERT: begin
               if (full) begin
                  if (oldest_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                     oldest_ff <= '0;
                  end else begin
                     oldest_ff <= oldest_ff + IDX_W'(1);
                  end
               end else begin
                  count_ff <= count_ff + CNT_W'(1);
               end
               lookup_rsp_ff.done   <= 1'b1;
               lookup_rsp_ff.is_new <= 1'b1;
               state_ff             <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign lookup_rsp = lookup_rsp_ff;

endmodule

`default_nettype wire

// File: sv/nsf_checker.sv
// Port-level checks for the new sender filter, attached to the top level
// by the bind at the end. Depends on nsf_pkg for the beat types.
`default_nettype none

module nsf_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input nsf_pkg::req_beat_type req_data,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input nsf_pkg::rsp_beat_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled response beat changed or dropped.");

   a_drop_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
      && (req_data.frame_kind == nsf_pkg::KIND_CONTROL
          || req_data.frame_kind == nsf_pkg::KIND_MISC)
      |=> !req_stall)
      else $error("Control or miscellaneous frame held the request side.");

   a_data_search: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.frame_kind == nsf_pkg::KIND_DATA
      |=> req_stall)
      else $error("Data frame was not searched.");

   a_rsp_after_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("Response appeared without a search in progress.");

endmodule

bind wlan_new_sender_filter nsf_checker u_nsf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: sim/wlan_new_sender_filter_test.sv
`timescale 1ns / 100ps
// Self-checking test of wlan_new_sender_filter: frame headers are sent over the request
// channel with random pacing and each new-sender report is checked against a tracked table.
// Depends on nsf_pkg and the wlan_new_sender_filter RTL.

module wlan_new_sender_filter_test;

   localparam int TABLE_DEPTH = 128;
   localparam int RANDOM_FRAMES = 750;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 20;
   localparam int CYCLE_LIMIT = 1000000;

   class new_sender_tracker;
      logic [nsf_pkg::MAC_W-1:0] seen [TABLE_DEPTH];
      int fill;
      int oldest;
      int mismatches;
      nsf_pkg::rsp_beat_type reports_due [$];

      function new();
         fill = 0;
         oldest = 0;
         mismatches = 0;
      endfunction

      function void take_frame(nsf_pkg::req_beat_type f);
         nsf_pkg::rsp_beat_type r;
         logic qualifies;
         int i;
         qualifies = 1'b0;
         r.report_kind = nsf_pkg::REPORT_BEACON;
         if (f.frame_kind == nsf_pkg::KIND_MGMT) begin
            qualifies = (f.frame_control == nsf_pkg::FC_BEACON
                         || f.frame_control == nsf_pkg::FC_PROBE_RESP)
                        && f.ssid_length != 8'd0 && f.ssid_length < nsf_pkg::SSID_LIMIT;
         end else if (f.frame_kind == nsf_pkg::KIND_DATA) begin
            qualifies = 1'b1;
            r.report_kind = nsf_pkg::REPORT_DATA;
         end
         if (!qualifies) return;
         for (i = 0; i < fill; i++) begin
            if (seen[i] == f.sender_mac) return;
         end
         if (fill < TABLE_DEPTH) begin
            seen[fill] = f.sender_mac;
            fill++;
         end else begin
            seen[oldest] = f.sender_mac;
            oldest = (oldest + 1) % TABLE_DEPTH;
         end
         r.new_mac = f.sender_mac;
         r.report_strength = f.signal_strength;
         reports_due.push_back(r);
      endfunction

      function void check_report(nsf_pkg::rsp_beat_type got);
         nsf_pkg::rsp_beat_type want;
         if (reports_due.size() == 0) begin
            $error("Unexpected report beat: new_mac %h", got.new_mac);
            mismatches++;
            return;
         end
         want = reports_due.pop_front();
         if (got.report_kind !== want.report_kind) begin
            $error("report_kind: expected %0d, actual %0d", want.report_kind, got.report_kind);
            mismatches++;
         end
         if (got.new_mac !== want.new_mac) begin
            $error("new_mac: expected %h, actual %h", want.new_mac, got.new_mac);
            mismatches++;
         end
         if (got.report_strength !== want.report_strength) begin
            $error("report_strength: expected %0d, actual %0d",
                   want.report_strength, got.report_strength);
            mismatches++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   nsf_pkg::req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   nsf_pkg::rsp_beat_type rsp_data;

   new_sender_tracker tracker = new();
   logic [nsf_pkg::MAC_W-1:0] macs_sent [$];
   int burst_left = 0;
   int stall_left = 0;
   int free_left = 0;
   int cycles = 0;

   wlan_new_sender_filter #(.TABLE_DEPTH(TABLE_DEPTH)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_report(rsp_data);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (free_left > 0) begin
            free_left--;
         end else begin
            free_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 25);
            stall_left = $urandom_range(1, 16);
         end
      end
   end

   function automatic nsf_pkg::req_beat_type frame_of(logic [1:0] kind, logic [7:0] fc,
                                                      logic [7:0] ssid,
                                                      logic [nsf_pkg::MAC_W-1:0] mac,
                                                      int rssi);
      nsf_pkg::req_beat_type f;
      f.frame_kind = kind;
      f.frame_control = fc;
      f.ssid_length = ssid;
      f.sender_mac = mac;
      f.signal_strength = rssi[7:0];
      return f;
   endfunction

   function automatic logic [nsf_pkg::MAC_W-1:0] pick_mac();
      logic [63:0] raw;
      int sel;
      int span;
      raw = {$urandom, $urandom};
      sel = $urandom_range(0, 99);
      if (sel < 20 && macs_sent.size() != 0) begin
         span = (macs_sent.size() > 100) ? 100 : macs_sent.size() - 1;
         return macs_sent[macs_sent.size() - 1 - $urandom_range(0, span)];
      end
      if (sel < 35 && macs_sent.size() != 0)
         return macs_sent[$urandom_range(0, macs_sent.size() - 1)];
      if (sel < 38) return ~(48'h1 << (raw[5:0] % 48));
      if (sel < 40) return 48'h1 << (raw[5:0] % 48);
      return raw[nsf_pkg::MAC_W-1:0];
   endfunction

   function automatic nsf_pkg::req_beat_type random_frame();
      nsf_pkg::req_beat_type f;
      int sel;
      f.frame_kind = 2'($urandom_range(0, 3));
      f.frame_control = 8'($urandom_range(0, 255));
      f.ssid_length = 8'($urandom_range(0, 255));
      f.sender_mac = pick_mac();
      f.signal_strength = 8'($urandom_range(0, 255));
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
         f.frame_kind = nsf_pkg::KIND_MGMT;
         f.frame_control = $urandom_range(0, 1) ? nsf_pkg::FC_BEACON
                                                : nsf_pkg::FC_PROBE_RESP;
         f.ssid_length = 8'($urandom_range(1, 32));
      end else if (sel < 70) begin
         f.frame_kind = nsf_pkg::KIND_DATA;
      end else if (sel < 80) begin
         f.frame_kind = nsf_pkg::KIND_MGMT;
         f.frame_control = $urandom_range(0, 1) ? nsf_pkg::FC_BEACON
                                                : nsf_pkg::FC_PROBE_RESP;
         f.ssid_length = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(33, 255));
      end
      return f;
   endfunction

   task automatic paced_send(input nsf_pkg::req_beat_type f);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= f;
      do @(posedge clock); while (req_stall);
      tracker.take_frame(f);
      macs_sent.push_back(f.sender_mac);
   endtask

   initial begin
      int k;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_BEACON, 8'd1, 48'h0, -128));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_PROBE_RESP, 8'd32,
                          48'hFFFF_FFFF_FFFF, 127));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_BEACON, 8'd0, 48'h1, 0));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_PROBE_RESP, 8'd33, 48'h2, 5));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_BEACON, 8'd255, 48'h3, -5));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, 8'h00, 8'd5, 48'h4, 10));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, 8'hFF, 8'd5, 48'h5, -10));
      paced_send(frame_of(nsf_pkg::KIND_DATA, 8'h00, 8'd0, 48'h0102_0304_0506, -1));
      paced_send(frame_of(nsf_pkg::KIND_DATA, 8'hFF, 8'd255, 48'h0, 1));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_BEACON, 8'd10,
                          48'h0102_0304_0506, -60));
      paced_send(frame_of(nsf_pkg::KIND_CONTROL, nsf_pkg::FC_BEACON, 8'd10,
                          48'hA0A0_A0A0_A0A0, -70));
      paced_send(frame_of(nsf_pkg::KIND_MISC, nsf_pkg::FC_PROBE_RESP, 8'd10,
                          48'h5A5A_5A5A_5A5A, -80));
      paced_send(frame_of(nsf_pkg::KIND_DATA, nsf_pkg::FC_BEACON, 8'd10,
                          48'hA0A0_A0A0_A0A0, -90));
      paced_send(frame_of(nsf_pkg::KIND_DATA, 8'h55, 8'hAA, 48'h8000_0000_0000, 127));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_PROBE_RESP, 8'd16,
                          48'h5A5A_5A5A_5A5A, -128));
      paced_send(frame_of(nsf_pkg::KIND_MGMT, nsf_pkg::FC_BEACON, 8'd32,
                          48'hFFFF_FFFF_FFFF, 0));
      paced_send(frame_of(nsf_pkg::KIND_DATA, 8'hAA, 8'h55, 48'h7FFF_FFFF_FFFF, -128));

      for (k = 0; k < RANDOM_FRAMES; k++) paced_send(random_frame());

      req_valid <= 1'b0;
      while (tracker.reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
